// ===== src/max_priority_queue_linear_scan_defines.svh =====
// Assertion macros for the max-priority queue checker.
// Used only by mpqls_checker.sv; relies on clock and reset in scope.
`ifndef MAX_PRIORITY_QUEUE_LINEAR_SCAN_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_LINEAR_SCAN_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MPQLS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mpqls assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MPQLS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mpqls assertion failed");

`endif

// ===== src/mpqls_pkg.sv =====
// Shared types and constants for the max-priority queue.
// No dependencies; used by every module of the block.
`default_nettype none

package mpqls_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int VALUE_W          = 32;
   localparam int COUNT_OUT_W      = 7;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SC_NONE,
      SC_LOAD,
      SC_OFFER
   } scan_cmd_type;

   typedef struct packed {
      scan_cmd_type              cmd;
      logic signed [VALUE_W-1:0] value;
   } scan_ctl_type;

endpackage

`default_nettype wire

// ===== src/mpqls_scan.sv =====
// Shared signed comparator with the running maximum and its slot index.
// Depends on mpqls_pkg for the command struct.
`default_nettype none

module mpqls_scan #(
   parameter int AW = 6
) (
   input  wire logic                                  clock,
   input  wire mpqls_pkg::scan_ctl_type               ctl,
   input  wire logic [AW-1:0]                         index,
   output logic signed [mpqls_pkg::VALUE_W-1:0]       best_value,
   output logic [AW-1:0]                              best_index,
   output logic                                       wins
);

   logic signed [mpqls_pkg::VALUE_W-1:0] best_value_ff;
   logic signed [mpqls_pkg::VALUE_W-1:0] best_value_in;
   logic [AW-1:0]                        best_index_ff;
   logic [AW-1:0]                        best_index_in;

   // strictly greater keeps the lowest index among equal maxima
   assign wins = ctl.value > best_value_ff;

   always_comb begin
      best_value_in = best_value_ff;
      best_index_in = best_index_ff;
      unique case (ctl.cmd)
         mpqls_pkg::SC_NONE: begin
         end
         mpqls_pkg::SC_LOAD: begin
            best_value_in = ctl.value;
            best_index_in = index;
         end
         mpqls_pkg::SC_OFFER: begin
            if (wins) begin
               best_value_in = ctl.value;
               best_index_in = index;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      best_value_ff <= best_value_in;
      best_index_ff <= best_index_in;
   end

   assign best_value = best_value_ff;
   assign best_index = best_index_ff;

endmodule

`default_nettype wire

// ===== src/max_priority_queue_linear_scan.sv =====
// Max-priority queue of signed 32-bit words in an unsorted store of CAPACITY
// entries. A push, a push onto a full store and a pop from an empty store are
// answered in the cycle after acceptance. A pop that leaves m > 0 entries
// goes through the move, scan, drain and finish states: the last entry is
// moved into the freed slot, then every remaining entry is read once through
// the single memory read port and fed to the one shared comparator to find
// the new maximum. The store needs no clearing after reset. A new word is
// taken only when the block is idle and the result register is free or being
// emptied. Depends on mpqls_pkg and mpqls_scan.
`default_nettype none

module max_priority_queue_linear_scan #(
   parameter int CAPACITY = mpqls_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_opcode,
   input  wire logic signed [mpqls_pkg::VALUE_W-1:0]   req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [mpqls_pkg::VALUE_W-1:0]        rsp_removed_value,
   output logic signed [mpqls_pkg::VALUE_W-1:0]        rsp_top_value,
   output logic [mpqls_pkg::COUNT_OUT_W-1:0]           rsp_entry_count,
   output logic                                        rsp_is_empty,
   output logic [1:0]                                  rsp_status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VW = mpqls_pkg::VALUE_W;

   mpqls_pkg::state_type state_ff;
   mpqls_pkg::state_type state_in;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [AW-1:0] scan_ff;
   logic [AW-1:0] scan_in;
   logic          lat_valid_ff;
   logic          lat_valid_in;
   logic [AW-1:0] lat_idx_ff;
   logic [AW-1:0] lat_idx_in;
   logic signed [VW-1:0] removed_hold_ff;
   logic signed [VW-1:0] removed_hold_in;

   logic                          rsp_valid_ff;
   logic signed [VW-1:0]          rsp_removed_ff;
   logic signed [VW-1:0]          rsp_top_ff;
   logic [mpqls_pkg::COUNT_OUT_W-1:0] rsp_count_ff;
   logic                          rsp_empty_ff;
   mpqls_pkg::status_type         rsp_status_ff;

   logic                          rsp_load;
   logic signed [VW-1:0]          resp_removed;
   logic signed [VW-1:0]          resp_top;
   logic [CW-1:0]                 resp_count;
   mpqls_pkg::status_type         resp_status;
   logic [CW+mpqls_pkg::COUNT_OUT_W-1:0] resp_count_wide;

   logic signed [VW-1:0] mem [CAPACITY];
   logic signed [VW-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [VW-1:0] wr_data;

   mpqls_pkg::scan_ctl_type scan_ctl;
   logic [AW-1:0]           scan_index;
   logic signed [VW-1:0]    best_value;
   logic [AW-1:0]           best_index;
   logic                    wins;

   logic          accept;
   logic          out_free;
   logic          is_full;
   logic          is_zero;
   logic [CW-1:0] count_dec;
   logic [CW-1:0] count_inc;
   logic [AW-1:0] last_idx;

   mpqls_scan #(
      .AW(AW)
   ) u_scan (
      .clock      (clock),
      .ctl        (scan_ctl),
      .index      (scan_index),
      .best_value (best_value),
      .best_index (best_index),
      .wins       (wins)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == mpqls_pkg::S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign is_full   = count_ff == CW'(CAPACITY);
   assign is_zero   = count_ff == '0;
   assign count_dec = count_ff - CW'(1);
   assign count_inc = count_ff + CW'(1);
   assign last_idx  = count_dec[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpqls_pkg::S_IDLE: begin
            if (accept && req_opcode == mpqls_pkg::OP_POP && !is_zero && count_dec != '0) begin
               state_in = mpqls_pkg::S_MOVE;
            end
         end
         mpqls_pkg::S_MOVE: begin
            state_in = mpqls_pkg::S_SCAN;
         end
         mpqls_pkg::S_SCAN: begin
            if (scan_ff == last_idx) begin
               state_in = mpqls_pkg::S_DRAIN;
            end
         end
         mpqls_pkg::S_DRAIN: begin
            state_in = mpqls_pkg::S_FINISH;
         end
         mpqls_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = mpqls_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mpqls_pkg::S_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      count_in        = count_ff;
      scan_in         = scan_ff;
      lat_valid_in    = 1'b0;
      lat_idx_in      = scan_ff;
      removed_hold_in = removed_hold_ff;
      rd_addr         = scan_ff;
      wr_en           = 1'b0;
      wr_addr         = count_ff[AW-1:0];
      wr_data         = req_value;
      scan_ctl.cmd    = mpqls_pkg::SC_NONE;
      scan_ctl.value  = rd_data_ff;
      scan_index      = lat_idx_ff;
      rsp_load        = 1'b0;
      resp_removed    = '0;
      resp_top        = '0;
      resp_count      = count_ff;
      resp_status     = mpqls_pkg::STAT_OK;

      // feed the word read last cycle to the comparator
      if (lat_valid_ff) begin
         scan_ctl.cmd = (lat_idx_ff == '0) ? mpqls_pkg::SC_LOAD : mpqls_pkg::SC_OFFER;
      end

      unique case (state_ff)
         mpqls_pkg::S_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               if (req_opcode == mpqls_pkg::OP_PUSH) begin
                  if (is_full) begin
                     resp_status = mpqls_pkg::STAT_FULL;
                     resp_top    = best_value;
                  end else begin
                     wr_en          = 1'b1;
                     scan_ctl.cmd   = is_zero ? mpqls_pkg::SC_LOAD : mpqls_pkg::SC_OFFER;
                     scan_ctl.value = req_value;
                     scan_index     = count_ff[AW-1:0];
                     resp_top       = (is_zero || wins) ? req_value : best_value;
                     resp_count     = count_inc;
                     count_in       = count_inc;
                  end
               end else begin
                  if (is_zero) begin
                     resp_status = mpqls_pkg::STAT_EMPTY;
                  end else begin
                     count_in        = count_dec;
                     removed_hold_in = best_value;
                     rd_addr         = last_idx;
                     resp_count      = count_dec;
                     if (count_dec == '0) begin
                        resp_removed = best_value;
                     end else begin
                        // result waits for the rescan
                        rsp_load = 1'b0;
                     end
                  end
               end
            end
         end
         mpqls_pkg::S_MOVE: begin
            // refill the freed slot with the last entry
            wr_en   = 1'b1;
            wr_addr = best_index;
            wr_data = rd_data_ff;
            scan_in = '0;
         end
         mpqls_pkg::S_SCAN: begin
            rd_addr      = scan_ff;
            scan_in      = scan_ff + AW'(1);
            lat_valid_in = 1'b1;
            lat_idx_in   = scan_ff;
         end
         mpqls_pkg::S_DRAIN: begin
         end
         mpqls_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               resp_removed = removed_hold_ff;
               resp_top     = best_value;
            end
         end
         default: begin
         end
      endcase
   end

   assign resp_count_wide = {{mpqls_pkg::COUNT_OUT_W{1'b0}}, resp_count};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpqls_pkg::S_IDLE;
         count_ff     <= '0;
         lat_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lat_valid_ff <= lat_valid_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff         <= scan_in;
      lat_idx_ff      <= lat_idx_in;
      removed_hold_ff <= removed_hold_in;
      if (rsp_load) begin
         rsp_removed_ff <= resp_removed;
         rsp_top_ff     <= resp_top;
         rsp_count_ff   <= resp_count_wide[mpqls_pkg::COUNT_OUT_W-1:0];
         rsp_empty_ff   <= resp_count == '0;
         rsp_status_ff  <= resp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

// ===== src/mpqls_checker.sv =====
// Port-level checks on the result channel of the max-priority queue.
// Depends on mpqls_pkg and the assertion macros header; bound to the top level.
`default_nettype none

`include "max_priority_queue_linear_scan_defines.svh"

module mpqls_checker #(
   parameter int CAPACITY = mpqls_pkg::DEFAULT_CAPACITY
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic signed [mpqls_pkg::VALUE_W-1:0]  rsp_removed_value,
   input wire logic signed [mpqls_pkg::VALUE_W-1:0]  rsp_top_value,
   input wire logic [mpqls_pkg::COUNT_OUT_W-1:0]     rsp_entry_count,
   input wire logic                                  rsp_is_empty,
   input wire logic [1:0]                            rsp_status
);

   localparam logic [mpqls_pkg::COUNT_OUT_W-1:0] FULL_COUNT =
      mpqls_pkg::COUNT_OUT_W'(CAPACITY);

   // an empty store reports no maximum
   `MPQLS_ASSERT_IMPL(empty_has_no_top, rsp_valid && rsp_is_empty, rsp_top_value == '0)

   // a rejected pop removes nothing and leaves the store empty
   `MPQLS_ASSERT_IMPL(empty_pop_clean, rsp_valid && rsp_status == mpqls_pkg::STAT_EMPTY, rsp_removed_value == '0 && rsp_is_empty && rsp_entry_count == '0)

   // a rejected push sees a full store and removes nothing
   `MPQLS_ASSERT_IMPL(full_push_clean, rsp_valid && rsp_status == mpqls_pkg::STAT_FULL, rsp_removed_value == '0 && !rsp_is_empty && rsp_entry_count == FULL_COUNT)

   // a stalled result word holds
   `MPQLS_ASSERT_NEXT(stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_top_value) && $stable(rsp_removed_value) && $stable(rsp_status))

endmodule

bind max_priority_queue_linear_scan mpqls_checker #(
   .CAPACITY(CAPACITY)
) u_mpqls_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_removed_value (rsp_removed_value),
   .rsp_top_value     (rsp_top_value),
   .rsp_entry_count   (rsp_entry_count),
   .rsp_is_empty      (rsp_is_empty),
   .rsp_status        (rsp_status)
);

`default_nettype wire
